>>> src/fpd_pkg.sv
package fpd_pkg;

	// length of the arctangent table, also the cap on iterations
	localparam int ATAN_LEN = 24;
	localparam int K_W = 5;

	localparam int SAMP_W = 10;
	localparam int PROD_W = 2 * SAMP_W;
	localparam int VEC_W = PROD_W + 1;
	localparam int PRESCALE_SH = 24;
	localparam int XY_W = 46;
	localparam int Z_W = 34;

	localparam logic [SAMP_W-1:0] BYTE_OFFSET_SUM = 10'd254;

	// atan(2^-k) in units of pi/2^31, rounded to nearest
	localparam logic [31:0] ATAN_UNITS [ATAN_LEN] = '{
		32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
		32'd42667331, 32'd21354465, 32'd10679838, 32'd5340245,
		32'd2670163, 32'd1335087, 32'd667544, 32'd333772,
		32'd166886, 32'd83443, 32'd41722, 32'd20861,
		32'd10430, 32'd5215, 32'd2608, 32'd1304,
		32'd652, 32'd326, 32'd163, 32'd81
	};

	// quarter turn, pi/2 in units of pi/2^31
	localparam logic [Z_W-1:0] QUARTER_TURN = 34'd1073741824;

	typedef struct packed {
		logic load;
		logic mul;
		logic pre;
		logic iter;
		logic emit;
		logic [K_W-1:0] k;
	} cmd_t;

endpackage

>>> src/fm_phase_discriminator_top.sv
// fm phase discriminator
// slave channel: one transaction carries two offset-binary i/q byte pairs; they are
// summed into one decimated complex sample. master channel: one transaction carries
// the phase step between this sample and the previous one, 32768 standing for pi.
// the very first transaction after reset only loads the history and yields nothing.
// each later item runs: multiply, pre-rotation, min(CORDIC_STEPS, 24) iterations of
// a shared shift-add cordic unit, and a rounding/output step; s_tready is high only
// while the controller is idle, so no new item is taken until the last one has left
// the rounding step.
// the result sits in an output register; the next item is accepted while it waits.
// if the receiver stalls, the finished phase waits in the rounding step until the
// output register frees, and no further item is taken in the meantime.
// reset clears the sample history, so the next item again gives no result, and
// drops any result not yet taken.
module fm_phase_discriminator_top #(
	parameter int ANGLE_BITS = 16,
	parameter int CORDIC_STEPS = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	input  logic [31:0] s_tdata, // i_first, q_first, i_second, q_second
	output logic m_tvalid,
	input  logic m_tready,
	output logic [15:0] m_tdata // phase_step
);

	fpd_pkg::cmd_t cmd;

	fpd_ctrl #(
		.CORDIC_STEPS(CORDIC_STEPS)
	) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.cmd(cmd)
	);

	fpd_datapath #(
		.ANGLE_BITS(ANGLE_BITS)
	) u_datapath (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.i_first(s_tdata[7:0]),
		.q_first(s_tdata[15:8]),
		.i_second(s_tdata[23:16]),
		.q_second(s_tdata[31:24]),
		.phase_step(m_tdata)
	);

	a_mul_then_pre: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.mul |=> cmd.pre)
		else $error("multiply step not followed by pre-rotation");

	a_pre_then_iter: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pre |=> cmd.iter && (cmd.k == '0))
		else $error("cordic did not start at step zero");

	a_busy_no_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.mul || cmd.pre || cmd.iter) |-> !s_tready)
		else $error("input accepted while an item is in flight");

	a_emit_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |=> m_tvalid)
		else $error("result emitted without output valid");

endmodule

>>> src/fpd_ctrl.sv
module fpd_ctrl #(
	parameter int CORDIC_STEPS = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	output logic m_tvalid,
	input  logic m_tready,
	output fpd_pkg::cmd_t cmd
);

	localparam int NSTEP = (CORDIC_STEPS < fpd_pkg::ATAN_LEN) ? CORDIC_STEPS : fpd_pkg::ATAN_LEN;
	localparam logic [fpd_pkg::K_W-1:0] LAST_K = fpd_pkg::K_W'(NSTEP - 1);

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_MUL  = 5'b00010,
		S_PRE  = 5'b00100,
		S_ITER = 5'b01000,
		S_DONE = 5'b10000
	} state_t;

	state_t state_q;
	logic have_prev_q;
	logic out_valid_q;
	logic [fpd_pkg::K_W-1:0] k_q;
	logic accept;
	logic can_emit;

	assign s_tready = (state_q == S_IDLE);
	assign accept = s_tvalid && s_tready;
	assign can_emit = !out_valid_q || m_tready;
	assign m_tvalid = out_valid_q;

	always_comb begin
		cmd.load = accept;
		cmd.mul = (state_q == S_MUL);
		cmd.pre = (state_q == S_PRE);
		cmd.iter = (state_q == S_ITER);
		cmd.emit = (state_q == S_DONE) && can_emit;
		cmd.k = k_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			have_prev_q <= 1'b0;
			out_valid_q <= 1'b0;
			k_q <= '0;
		end else begin
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						have_prev_q <= 1'b1;
						// the first sample after reset only primes the history
						if (have_prev_q) begin
							state_q <= S_MUL;
						end
					end
				end
				S_MUL: begin
					state_q <= S_PRE;
				end
				S_PRE: begin
					k_q <= '0;
					state_q <= S_ITER;
				end
				S_ITER: begin
					k_q <= k_q + 1'b1;
					if (k_q == LAST_K) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (can_emit) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

>>> src/fpd_datapath.sv
module fpd_datapath #(
	parameter int ANGLE_BITS = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  fpd_pkg::cmd_t cmd,
	input  logic [7:0] i_first,
	input  logic [7:0] q_first,
	input  logic [7:0] i_second,
	input  logic [7:0] q_second,
	output logic [15:0] phase_step
);

	localparam int SH = 32 - ANGLE_BITS;
	localparam int SW = fpd_pkg::SAMP_W;
	localparam int PW = fpd_pkg::PROD_W;
	localparam int VW = fpd_pkg::VEC_W;
	localparam int XW = fpd_pkg::XY_W;
	localparam int ZW = fpd_pkg::Z_W;

	logic signed [SW-1:0] cur_re, cur_im;
	logic signed [SW-1:0] prev_re_q, prev_im_q;
	logic signed [SW-1:0] pr_s1, pi_s1, cr_s1, ci_s1;
	logic signed [PW-1:0] m_rr_s2, m_ii_s2, m_ri_s2, m_ir_s2;
	logic signed [VW-1:0] zr, zj;
	logic signed [VW-1:0] xv, yv;
	logic signed [ZW-1:0] z0;
	logic signed [XW-1:0] x_q, y_q;
	logic signed [ZW-1:0] z_q;
	logic zero_q;
	logic signed [XW-1:0] dx, dy;
	logic signed [ZW-1:0] step_ang;
	logic [ZW-1:0] rounded;
	logic [31:0] keep_mask;
	logic [31:0] kept;
	logic [15:0] phase_q;

	assign cur_re = SW'({2'b00, i_first} + {2'b00, i_second} - fpd_pkg::BYTE_OFFSET_SUM);
	assign cur_im = SW'({2'b00, q_first} + {2'b00, q_second} - fpd_pkg::BYTE_OFFSET_SUM);

	// conjugate product components, exact
	assign zr = VW'(m_rr_s2) + VW'(m_ii_s2);
	assign zj = VW'(m_ri_s2) - VW'(m_ir_s2);

	// move the vector into the right half-plane
	always_comb begin
		xv = zr;
		yv = zj;
		z0 = '0;
		if (zr < 0) begin
			if (zj >= 0) begin
				xv = zj;
				yv = -zr;
				z0 = fpd_pkg::QUARTER_TURN;
			end else begin
				xv = -zj;
				yv = zr;
				z0 = -fpd_pkg::QUARTER_TURN;
			end
		end
	end

	assign dx = y_q >>> cmd.k;
	assign dy = x_q >>> cmd.k;
	assign step_ang = ZW'(fpd_pkg::ATAN_UNITS[cmd.k]);

	// round half up and keep the top ANGLE_BITS of the 32-bit turn
	assign rounded = z_q + (ZW'(1) << (SH - 1));
	assign keep_mask = ~((32'(1) << SH) - 32'(1));
	assign kept = rounded[31:0] & keep_mask;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_re_q <= '0;
			prev_im_q <= '0;
		end else if (cmd.load) begin
			prev_re_q <= cur_re;
			prev_im_q <= cur_im;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			pr_s1 <= prev_re_q;
			pi_s1 <= prev_im_q;
			cr_s1 <= cur_re;
			ci_s1 <= cur_im;
		end
		if (cmd.mul) begin
			m_rr_s2 <= pr_s1 * cr_s1;
			m_ii_s2 <= pi_s1 * ci_s1;
			m_ri_s2 <= pr_s1 * ci_s1;
			m_ir_s2 <= pi_s1 * cr_s1;
		end
		if (cmd.pre) begin
			x_q <= XW'(xv) <<< fpd_pkg::PRESCALE_SH;
			y_q <= XW'(yv) <<< fpd_pkg::PRESCALE_SH;
			z_q <= z0;
			zero_q <= (zr == '0) && (zj == '0);
		end else if (cmd.iter) begin
			if (!y_q[XW-1]) begin
				x_q <= x_q + dx;
				y_q <= y_q - dy;
				z_q <= z_q + step_ang;
			end else begin
				x_q <= x_q - dx;
				y_q <= y_q + dy;
				z_q <= z_q - step_ang;
			end
		end
		if (cmd.emit) begin
			phase_q <= zero_q ? 16'h0000 : kept[31:16];
		end
	end

	assign phase_step = phase_q;

endmodule

>>> tb/testbench.sv
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int ANGLE_BITS = 16;
	localparam int CORDIC_STEPS = 16;
	localparam int TABLE_LEN = 24;
	localparam int LATENCY = (CORDIC_STEPS < TABLE_LEN ? CORDIC_STEPS : TABLE_LEN) + 4;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int BYTE_PAIR_OFFSET = 254;
	localparam longint HALF_PI_UNITS = 64'sd1073741824;
	localparam longint PRESCALE = 64'sd16777216;

	// atan(2^-k) in units of pi/2^31
	localparam longint ATAN_STEP [TABLE_LEN] = '{
		536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
		10679838, 5340245, 2670163, 1335087, 667544, 333772,
		166886, 83443, 41722, 20861, 10430, 5215,
		2608, 1304, 652, 326, 163, 81
	};

	typedef enum int {
		PAT_UNIFORM,
		PAT_NEAR_ZERO,
		PAT_EXTREME,
		PAT_DRIFT
	} pattern_t;

	logic clk;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	logic [31:0] s_tdata; // i_first, q_first, i_second, q_second
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [15:0] m_tdata; // phase_step

	// expected phase steps in order of arrival
	logic [15:0] pending_phase [$];

	// sample history of the predictor
	int hist_re;
	int hist_im;
	bit hist_valid;

	int errors;
	int cycles;
	int send_idle_pct;
	int recv_stall_pct;
	int hold_left;
	int stall_left;
	logic [31:0] last_item;

	fm_phase_discriminator_top #(
		.ANGLE_BITS(ANGLE_BITS),
		.CORDIC_STEPS(CORDIC_STEPS)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d phase steps outstanding",
				cycles, pending_phase.size());
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	function automatic logic [15:0] phase_step_of(longint zr, longint zj);
		longint x;
		longint y;
		longint z;
		longint t;
		longint dx;
		longint dy;
		logic [63:0] u;
		logic [63:0] a;
		int sh;
		if (zr == 0 && zj == 0)
			return 16'd0;
		x = zr * PRESCALE;
		y = zj * PRESCALE;
		z = 0;
		// move the vector into the right half-plane
		if (x < 0) begin
			t = x;
			if (y >= 0) begin
				x = y;
				y = -t;
				z = HALF_PI_UNITS;
			end else begin
				x = -y;
				y = t;
				z = -HALF_PI_UNITS;
			end
		end
		for (int k = 0; k < CORDIC_STEPS && k < TABLE_LEN; k++) begin
			dx = y >>> k;
			dy = x >>> k;
			if (y >= 0) begin
				x = x + dx;
				y = y - dy;
				z = z + ATAN_STEP[k];
			end else begin
				x = x - dx;
				y = y + dy;
				z = z - ATAN_STEP[k];
			end
		end
		sh = 32 - ANGLE_BITS;
		u = 64'(z) + (64'd1 << (sh - 1));
		a = (u >> sh) & ((64'd1 << ANGLE_BITS) - 64'd1);
		if (ANGLE_BITS >= 16)
			return 16'(a >> (ANGLE_BITS - 16));
		return 16'(a << (16 - ANGLE_BITS));
	endfunction

	task automatic predict_phase(input logic [31:0] item);
		int cur_re;
		int cur_im;
		longint zr;
		longint zj;
		cur_re = int'(item[7:0]) + int'(item[23:16]) - BYTE_PAIR_OFFSET;
		cur_im = int'(item[15:8]) + int'(item[31:24]) - BYTE_PAIR_OFFSET;
		// conj(previous) * current
		zr = longint'(hist_re) * cur_re + longint'(hist_im) * cur_im;
		zj = longint'(hist_re) * cur_im - longint'(hist_im) * cur_re;
		if (hist_valid)
			pending_phase.push_back(phase_step_of(zr, zj));
		hist_re = cur_re;
		hist_im = cur_im;
		hist_valid = 1'b1;
	endtask

	task automatic report_error(input string msg);
		$display("ERROR @%0t: %s", $realtime, msg);
		errors++;
	endtask

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_phase.size() == 0) begin
				report_error($sformatf("phase_step %0d with none expected",
					$signed(m_tdata)));
			end else begin
				if (m_tdata !== pending_phase[0])
					report_error($sformatf("phase_step got %0d expected %0d",
						$signed(m_tdata), $signed(pending_phase[0])));
				void'(pending_phase.pop_front());
			end
		end
	end

	// result side: random stalls, with occasional runs, and the long hold-off
	always @(negedge clk) begin
		if (hold_left > 0) begin
			m_tready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (stall_left > 0) begin
			m_tready <= 1'b0;
			stall_left <= stall_left - 1;
		end else if (recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct) begin
			m_tready <= 1'b0;
			if ($urandom_range(7) == 0)
				stall_left <= $urandom_range(2, 40);
		end else begin
			m_tready <= 1'b1;
		end
	end

	// called and returns at a falling edge
	task automatic send_item(input logic [31:0] item);
		if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 25)) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= item;
		do @(posedge clk); while (!s_tready);
		predict_phase(item);
		last_item = item;
		@(negedge clk);
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (pending_phase.size() != 0)
			@(negedge clk);
	endtask

	function automatic logic [31:0] pack_item(input logic [7:0] i0, input logic [7:0] q0,
			input logic [7:0] i1, input logic [7:0] q1);
		return {q1, i1, q0, i0};
	endfunction

	function automatic logic [7:0] nudge(input logic [7:0] b, input int span);
		int v;
		v = int'(b) + $urandom_range(0, 2 * span) - span;
		if (v < 0)
			v = 0;
		if (v > 255)
			v = 255;
		return 8'(v);
	endfunction

	function automatic logic [7:0] extreme_byte();
		case ($urandom_range(3))
			0: return 8'd0;
			1: return 8'd255;
			2: return 8'd127;
			default: return 8'd128;
		endcase
	endfunction

	function automatic logic [31:0] random_item();
		pattern_t pat;
		int pick;
		logic [31:0] item;
		pick = $urandom_range(99);
		if (pick < 45)
			pat = PAT_UNIFORM;
		else if (pick < 60)
			pat = PAT_NEAR_ZERO;
		else if (pick < 75)
			pat = PAT_EXTREME;
		else
			pat = PAT_DRIFT;
		case (pat)
			PAT_UNIFORM: item = $urandom;
			PAT_NEAR_ZERO: begin
				for (int b = 0; b < 4; b++)
					item[8*b +: 8] = nudge(8'd127, 2);
			end
			PAT_EXTREME: begin
				for (int b = 0; b < 4; b++)
					item[8*b +: 8] = extreme_byte();
			end
			default: begin
				// slowly moving carrier, small phase steps
				for (int b = 0; b < 4; b++)
					item[8*b +: 8] = nudge(last_item[8*b +: 8], 6);
			end
		endcase
		return item;
	endfunction

	task automatic test_directed();
		// the first transaction only loads the history
		send_item(pack_item(8'd127, 8'd127, 8'd127, 8'd127));
		// zero product against a zero history
		send_item(pack_item(8'd255, 8'd127, 8'd255, 8'd127));
		send_item(pack_item(8'd255, 8'd127, 8'd255, 8'd127));
		// half turn wraps to the most negative code
		send_item(pack_item(8'd0, 8'd127, 8'd0, 8'd127));
		send_item(pack_item(8'd127, 8'd255, 8'd127, 8'd255));
		send_item(pack_item(8'd127, 8'd0, 8'd127, 8'd0));
		send_item(pack_item(8'd255, 8'd255, 8'd255, 8'd255));
		send_item(pack_item(8'd0, 8'd0, 8'd0, 8'd0));
		send_item(pack_item(8'd0, 8'd255, 8'd255, 8'd0));
		send_item(pack_item(8'd255, 8'd0, 8'd0, 8'd255));
		// unit vectors on each axis
		send_item(pack_item(8'd128, 8'd127, 8'd127, 8'd127));
		send_item(pack_item(8'd127, 8'd128, 8'd127, 8'd127));
		send_item(pack_item(8'd126, 8'd127, 8'd127, 8'd127));
		send_item(pack_item(8'd127, 8'd126, 8'd127, 8'd127));
		send_item(pack_item(8'd127, 8'd127, 8'd127, 8'd127));
		send_item(pack_item(8'd200, 8'd50, 8'd10, 8'd240));
		send_item(pack_item(8'd255, 8'd0, 8'd255, 8'd0));
		send_item(pack_item(8'd0, 8'd255, 8'd0, 8'd255));
		send_item(pack_item(8'd1, 8'd2, 8'd3, 8'd4));
		send_item(pack_item(8'd254, 8'd253, 8'd252, 8'd251));
		wait_drained();
	endtask

	task automatic test_random(input int count, input int idle_pct, input int stall_pct);
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		for (int n = 0; n < count; n++)
			send_item(random_item());
		wait_drained();
	endtask

	task automatic test_output_backpressure();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_left = 400;
		// block fills and stalls its input while the result side is held off
		for (int n = 0; n < 12; n++)
			send_item(random_item());
		wait_drained();
	endtask

	task automatic test_drain_pause();
		send_idle_pct = 20;
		recv_stall_pct = 20;
		for (int r = 0; r < 4; r++) begin
			for (int n = 0; n < 6; n++)
				send_item(random_item());
			wait_drained();
		end
	endtask

	initial begin
		errors = 0;
		cycles = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_left = 0;
		stall_left = 0;
		hist_re = 0;
		hist_im = 0;
		hist_valid = 1'b0;
		last_item = 32'h7f7f7f7f;
		s_tvalid = 1'b0;
		s_tdata = '0;
		arst_n = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_directed();
		test_random(370, 0, 0);
		test_random(370, 46, 0);
		test_random(370, 0, 46);
		test_random(370, 14, 14);
		test_output_backpressure();
		test_drain_pause();

		wait_drained();
		repeat (LATENCY + 20) @(negedge clk);
		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
